>>> rtl/rpn_pkg.sv
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared types, token codes and status codes of the postfix evaluator.
// ----------------------------------------------------------------------------
package rpn_pkg;

    typedef enum logic [4:0] {
        OP_LIT    = 5'd0,  OP_GETVAR = 5'd1,  OP_SETVAR = 5'd2,  OP_FINISH = 5'd3,
        OP_EQ     = 5'd4,  OP_NE     = 5'd5,  OP_LT     = 5'd6,  OP_GT     = 5'd7,
        OP_LE     = 5'd8,  OP_GE     = 5'd9,  OP_LAND   = 5'd10, OP_LOR    = 5'd11,
        OP_LXOR   = 5'd12, OP_BAND   = 5'd13, OP_BOR    = 5'd14, OP_BXOR   = 5'd15,
        OP_MUL    = 5'd16, OP_DIV    = 5'd17, OP_MOD    = 5'd18, OP_ADD    = 5'd19,
        OP_SUB    = 5'd20, OP_SHL    = 5'd21, OP_SHR    = 5'd22, OP_NEG    = 5'd23,
        OP_PLUS   = 5'd24, OP_LNOT   = 5'd25, OP_CPL    = 5'd26, OP_SEL    = 5'd27,
        OP_U28    = 5'd28, OP_U29    = 5'd29, OP_U30    = 5'd30, OP_U31    = 5'd31
    } t_op;

    localparam logic [3:0] ST_OK       = 4'd0;
    localparam logic [3:0] ST_OVERFLOW = 4'd1;
    localparam logic [3:0] ST_UNDERFLW = 4'd2;
    localparam logic [3:0] ST_DIVZERO  = 4'd3;
    localparam logic [3:0] ST_NOREAD   = 4'd4;
    localparam logic [3:0] ST_BADVALUE = 4'd5;
    localparam logic [3:0] ST_NOWRITE  = 4'd6;
    localparam logic [3:0] ST_DEPTH    = 4'd7;
    localparam logic [3:0] ST_UNKNOWN  = 4'd8;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_RESULT = 1'b1;

    localparam logic [0:0] REG_RD_EN = 1'b0;
    localparam logic [0:0] REG_WR_EN = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE, S_RD1, S_RD2, S_RD3, S_WAIT, S_EXEC, S_MUL, S_DIV, S_FIN, S_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic       load;     // capture token
        logic       rd_top;   // issue read of entry sp-1
        logic       rd_next;  // issue read of sp-2
        logic       rd_third; // issue read of sp-3
        logic       rd_zero;  // issue read of entry 0
        logic       cap_b;    // capture read data into b
        logic       cap_a;    // capture read data into a
        logic       cap_c;    // capture read data into c
        logic       mul_go;
        logic       div_go;
        logic       exec;     // retire token: update stack, error, output
        logic       fin;      // retire finish
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        t_op        op;
        logic       mul_busy;
        logic       div_busy;
        logic       out_full;
    } t_sts;

endpackage

>>> rtl/rpn_ctrl.sv
// ----------------------------------------------------------------------------
// rpn_ctrl
// Token sequencer: reads operands, starts long units, retires each item.
// ----------------------------------------------------------------------------
module rpn_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  rpn_pkg::t_sts    i_sts,
    output rpn_pkg::t_cmd    o_cmd
);
    rpn_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= rpn_pkg::S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            rpn_pkg::S_IDLE: if (i_in_valid) n_state = rpn_pkg::S_RD1;
            rpn_pkg::S_RD1: begin
                if (i_sts.op == rpn_pkg::OP_FINISH) n_state = rpn_pkg::S_FIN;
                else                               n_state = rpn_pkg::S_RD2;
            end
            rpn_pkg::S_RD2: n_state = rpn_pkg::S_RD3;
            rpn_pkg::S_RD3: n_state = rpn_pkg::S_WAIT;
            rpn_pkg::S_WAIT: begin
                if (i_sts.op == rpn_pkg::OP_MUL) n_state = rpn_pkg::S_MUL;
                else if (i_sts.op == rpn_pkg::OP_DIV || i_sts.op == rpn_pkg::OP_MOD)
                    n_state = rpn_pkg::S_DIV;
                else n_state = rpn_pkg::S_EXEC;
            end
            rpn_pkg::S_MUL: if (!i_sts.mul_busy) n_state = rpn_pkg::S_EXEC;
            rpn_pkg::S_DIV: if (!i_sts.div_busy) n_state = rpn_pkg::S_EXEC;
            rpn_pkg::S_EXEC: n_state = rpn_pkg::S_OUT;
            rpn_pkg::S_FIN:  n_state = rpn_pkg::S_OUT;
            rpn_pkg::S_OUT:  if (!i_sts.out_full) n_state = rpn_pkg::S_IDLE;
            default:         n_state = rpn_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = (r_state != rpn_pkg::S_IDLE);
        case (r_state)
            rpn_pkg::S_IDLE: o_cmd.load = i_in_valid;
            rpn_pkg::S_RD1: begin
                o_cmd.rd_top  = (i_sts.op != rpn_pkg::OP_FINISH);
                o_cmd.rd_zero = (i_sts.op == rpn_pkg::OP_FINISH);
            end
            rpn_pkg::S_RD2: begin
                o_cmd.rd_next = 1'b1;
                o_cmd.cap_b   = 1'b1;
            end
            rpn_pkg::S_RD3: begin
                o_cmd.rd_third = 1'b1;
                o_cmd.cap_a    = 1'b1;
            end
            rpn_pkg::S_WAIT: begin
                o_cmd.cap_c  = 1'b1;
                o_cmd.mul_go = (i_sts.op == rpn_pkg::OP_MUL);
                o_cmd.div_go = (i_sts.op == rpn_pkg::OP_DIV || i_sts.op == rpn_pkg::OP_MOD);
            end
            rpn_pkg::S_EXEC: o_cmd.exec = 1'b1;
            rpn_pkg::S_FIN: begin
                o_cmd.cap_b = 1'b1;
                o_cmd.fin   = 1'b1;
            end
            default: ;
        endcase
    end
endmodule

>>> rtl/rpn_div.sv
// ----------------------------------------------------------------------------
// rpn_div
// Radix-2 restoring divider on magnitudes, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rpn_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_busy,
    output logic [63:0] o_quo,
    output logic [63:0] o_rem
);
    logic [63:0] r_q, r_r, r_d;
    logic [6:0]  r_cnt;
    logic        r_busy, r_qneg, r_rneg;
    logic [64:0] w_trial;
    logic [63:0] w_ma, w_mb;

    assign w_ma    = i_a[63] ? (64'd0 - i_a) : i_a;
    assign w_mb    = i_b[63] ? (64'd0 - i_b) : i_b;
    assign w_trial = {r_r, r_q[63]} - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_go) begin
            r_busy <= 1'b1;
            r_cnt  <= 7'd64;
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 7'd1;
            r_busy <= (r_cnt != 7'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_q    <= w_ma;
            r_r    <= '0;
            r_d    <= w_mb;
            r_qneg <= i_a[63] ^ i_b[63];
            r_rneg <= i_a[63];
        end else if (r_busy) begin
            if (!w_trial[64]) begin
                r_r <= w_trial[63:0];
                r_q <= {r_q[62:0], 1'b1};
            end else begin
                r_r <= {r_r[62:0], r_q[63]};
                r_q <= {r_q[62:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_qneg ? (64'd0 - r_q) : r_q;
    assign o_rem  = r_rneg ? (64'd0 - r_r) : r_r;
endmodule

>>> rtl/rpn_dp.sv
// ----------------------------------------------------------------------------
// rpn_dp
// Stack memory, operand registers, ALU, error state and output register.
// ----------------------------------------------------------------------------
module rpn_dp #(
    parameter int STACK_DEPTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rpn_pkg::t_cmd        i_cmd,
    output rpn_pkg::t_sts        o_sts,
    input  logic                 i_cfg_we,
    input  logic [0:0]           i_cfg_idx,
    input  logic [0:0]           i_cfg_data,
    input  logic [4:0]           i_operation,
    input  logic signed [63:0]   i_operand_value,
    input  logic [15:0]          i_var_id,
    input  logic                 i_value_valid,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_result_kind,
    output logic [15:0]          o_var_id_out,
    output logic signed [63:0]   o_value_out,
    output logic [3:0]           o_status,
    output logic [$clog2(STACK_DEPTH+1)-1:0] o_sp
);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int PW = $clog2(STACK_DEPTH + 1);
    localparam logic [PW-1:0] DEPTH_P = PW'(STACK_DEPTH);

    logic [63:0] r_mem [STACK_DEPTH];
    logic [63:0] r_rd;
    logic [PW-1:0] r_sp;
    logic [3:0]  r_err;
    logic        r_rd_en, r_wr_en;
    rpn_pkg::t_op r_op;
    logic [63:0] r_opnd, r_a, r_b, r_c, r_mul;
    logic [15:0] r_vid;
    logic        r_vv;
    logic        r_ov;
    logic        r_ok;
    logic        r_kind;
    logic [15:0] r_ovid;
    logic [63:0] r_oval;
    logic [3:0]  r_ost;
    logic [1:0]  r_mstep;
    logic        r_mbusy;

    logic        w_rd_go;
    logic [PW-1:0] w_rd_addr;
    logic        w_div_busy;
    logic [63:0] w_quo, w_rem;
    logic [31:0] w_mx, w_my;
    logic [63:0] w_pp;

    assign w_rd_go = i_cmd.rd_top | i_cmd.rd_next | i_cmd.rd_third | i_cmd.rd_zero;
    always_comb begin
        w_rd_addr = '0;
        if (i_cmd.rd_top)   w_rd_addr = r_sp - PW'(1);
        if (i_cmd.rd_next)  w_rd_addr = r_sp - PW'(2);
        if (i_cmd.rd_third) w_rd_addr = r_sp - PW'(3);
    end

    rpn_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(i_cmd.div_go),
        .i_a(r_a), .i_b(r_b), .o_busy(w_div_busy), .o_quo(w_quo), .o_rem(w_rem)
    );

    // operand captures; reads for absent operands return junk that is never used
    always_ff @(posedge i_clk) begin
        if (w_rd_go) r_rd <= r_mem[w_rd_addr[AW-1:0]];
        if (i_cmd.load) begin
            r_op   <= rpn_pkg::t_op'(i_operation);
            r_opnd <= i_operand_value;
            r_vid  <= i_var_id;
            r_vv   <= i_value_valid;
        end
        if (i_cmd.cap_b) r_b <= r_rd;
        if (i_cmd.cap_a) r_a <= r_rd;
        if (i_cmd.cap_c) r_c <= r_rd;
    end

    // low 64 bits of a*b from three 32x32 partial products, one per cycle:
    // aL*bL, then (aL*bH) << 32, then (aH*bL) << 32
    always_comb begin
        w_mx = r_a[31:0];
        w_my = r_b[31:0];
        case (r_mstep)
            2'd1:    w_my = r_b[63:32];
            2'd2:    w_mx = r_a[63:32];
            default: ;
        endcase
    end
    assign w_pp = 64'(w_mx) * 64'(w_my);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
            r_mstep <= '0;
        end else if (i_cmd.mul_go) begin
            r_mbusy <= 1'b1;
            r_mstep <= '0;
        end else if (r_mbusy) begin
            r_mstep <= r_mstep + 2'd1;
            r_mbusy <= (r_mstep != 2'd2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_go) r_mul <= '0;
        else if (r_mbusy)
            r_mul <= r_mul + ((r_mstep == 2'd0) ? w_pp : {w_pp[31:0], 32'd0});
    end

    // after the three captures: b=top, a=second, c=third
    logic [63:0] w_res;
    logic [3:0]  w_need;   // operands popped
    logic [5:0]  w_sh;
    always_comb begin
        w_sh   = r_b[5:0];
        w_res  = '0;
        w_need = 4'd2;
        case (r_op)
            rpn_pkg::OP_EQ:   w_res = 64'(r_a == r_b);
            rpn_pkg::OP_NE:   w_res = 64'(r_a != r_b);
            rpn_pkg::OP_LT:   w_res = 64'($signed(r_a) < $signed(r_b));
            rpn_pkg::OP_GT:   w_res = 64'($signed(r_a) > $signed(r_b));
            rpn_pkg::OP_LE:   w_res = 64'($signed(r_a) <= $signed(r_b));
            rpn_pkg::OP_GE:   w_res = 64'($signed(r_a) >= $signed(r_b));
            rpn_pkg::OP_LAND: w_res = 64'((r_a != 0) && (r_b != 0));
            rpn_pkg::OP_LOR:  w_res = 64'((r_a != 0) || (r_b != 0));
            rpn_pkg::OP_LXOR: w_res = 64'((r_a != 0) ^ (r_b != 0));
            rpn_pkg::OP_BAND: w_res = r_a & r_b;
            rpn_pkg::OP_BOR:  w_res = r_a | r_b;
            rpn_pkg::OP_BXOR: w_res = r_a ^ r_b;
            rpn_pkg::OP_MUL:  w_res = r_mul;
            rpn_pkg::OP_DIV:  w_res = w_quo;
            rpn_pkg::OP_MOD:  w_res = w_rem;
            rpn_pkg::OP_ADD:  w_res = r_a + r_b;
            rpn_pkg::OP_SUB:  w_res = r_a - r_b;
            rpn_pkg::OP_SHL:  w_res = r_a << w_sh;
            rpn_pkg::OP_SHR:  w_res = 64'($signed(r_a) >>> w_sh);
            rpn_pkg::OP_NEG:  begin w_res = 64'd0 - r_b; w_need = 4'd1; end
            rpn_pkg::OP_PLUS: begin w_res = r_b;         w_need = 4'd1; end
            rpn_pkg::OP_LNOT: begin w_res = 64'(r_b == 0); w_need = 4'd1; end
            rpn_pkg::OP_CPL:  begin w_res = ~r_b;        w_need = 4'd1; end
            rpn_pkg::OP_SEL:  begin w_res = (r_c != 0) ? r_a : r_b; w_need = 4'd3; end
            default: ;
        endcase
    end

    logic w_push, w_emit;
    logic [3:0] w_new_err;
    logic [PW-1:0] w_new_sp;
    logic [63:0] w_push_val;
    always_comb begin
        w_push     = 1'b0;
        w_emit     = 1'b0;
        w_new_err  = rpn_pkg::ST_OK;
        w_new_sp   = r_sp;
        w_push_val = w_res;
        case (r_op) inside
            rpn_pkg::OP_LIT, rpn_pkg::OP_GETVAR: begin
                w_push_val = r_opnd;
                if (r_op == rpn_pkg::OP_GETVAR && !r_rd_en) w_new_err = rpn_pkg::ST_NOREAD;
                else if (r_op == rpn_pkg::OP_GETVAR && !r_vv)
                    w_new_err = rpn_pkg::ST_BADVALUE;
                else if (r_sp >= DEPTH_P) w_new_err = rpn_pkg::ST_OVERFLOW;
                else w_push = 1'b1;
            end
            rpn_pkg::OP_SETVAR: begin
                if (r_sp == '0)    w_new_err = rpn_pkg::ST_UNDERFLW;
                else if (!r_wr_en) w_new_err = rpn_pkg::ST_NOWRITE;
                else               w_emit = 1'b1;
            end
            [rpn_pkg::OP_EQ:rpn_pkg::OP_SEL]: begin
                if (r_sp < PW'(w_need)) w_new_err = rpn_pkg::ST_UNDERFLW;
                else if ((r_op == rpn_pkg::OP_DIV || r_op == rpn_pkg::OP_MOD) && r_b == 0)
                    begin w_new_sp = r_sp - PW'(2); w_new_err = rpn_pkg::ST_DIVZERO; end
                else begin
                    w_new_sp = r_sp - PW'(w_need);
                    w_push   = 1'b1;
                end
            end
            default: w_new_err = rpn_pkg::ST_UNKNOWN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && r_err == rpn_pkg::ST_OK && w_push)
            r_mem[w_new_sp[AW-1:0]] <= w_push_val;
        if (i_cmd.exec) begin
            r_kind <= rpn_pkg::KIND_WRITE;
            r_ovid <= r_vid;
            r_oval <= r_b;
            r_ost  <= rpn_pkg::ST_OK;
        end
        if (i_cmd.fin) begin
            r_kind <= rpn_pkg::KIND_RESULT;
            r_ovid <= '0;
            r_oval <= (r_err == rpn_pkg::ST_OK && r_sp == PW'(1)) ? r_rd : 64'd0;
            r_ost  <= (r_err != rpn_pkg::ST_OK) ? r_err :
                      (r_sp != PW'(1)) ? rpn_pkg::ST_DEPTH : rpn_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp    <= '0;
            r_err   <= rpn_pkg::ST_OK;
            r_rd_en <= 1'b0;
            r_wr_en <= 1'b0;
            r_ov    <= 1'b0;
            r_ok    <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_idx == rpn_pkg::REG_RD_EN) r_rd_en <= i_cfg_data[0];
            if (i_cfg_we && i_cfg_idx == rpn_pkg::REG_WR_EN) r_wr_en <= i_cfg_data[0];
            if (o_out_valid && !i_out_stall) r_ov <= 1'b0;
            if (i_cmd.exec && r_err == rpn_pkg::ST_OK) begin
                if (w_new_err != rpn_pkg::ST_OK) begin
                    r_err <= w_new_err;
                    if (w_new_err != rpn_pkg::ST_OVERFLOW) r_sp <= w_new_sp;
                end else begin
                    r_sp <= w_new_sp + PW'(w_push);
                end
                r_ov <= w_emit;
            end
            if (i_cmd.fin) begin
                r_sp  <= '0;
                r_err <= rpn_pkg::ST_OK;
                r_ov  <= 1'b1;
            end
            r_ok <= 1'b1;
        end
    end

    assign o_out_valid   = r_ov;
    assign o_result_kind = r_kind;
    assign o_var_id_out  = r_ovid;
    assign o_value_out   = r_oval;
    assign o_status      = r_ost;
    assign o_sp          = r_sp;
    assign o_sts.op       = r_op;
    assign o_sts.mul_busy = r_mbusy | i_cmd.mul_go;
    assign o_sts.div_busy = w_div_busy | i_cmd.div_go;
    assign o_sts.out_full = r_ov & i_out_stall & r_ok;
endmodule

>>> rtl/rpn_stack_expression_evaluator_top.sv
// ----------------------------------------------------------------------------
// rpn_stack_expression_evaluator_top
// Postfix evaluator of 64-bit signed integers on a bounded value stack.
// ----------------------------------------------------------------------------
// One token is taken per item and worked on alone. Each token is loaded,
// then its operands are read one at a time from the stack memory, which has
// a single read port (states RD1, RD2, RD3), then it waits, executes and
// outputs; mul first waits on one 32x32 multiplier (three partial products
// on successive cycles), div and mod on a radix-2 divider (one quotient bit
// per cycle). Finish reads entry 0 and goes to output. A result sits in the
// output register; the next token is taken only once that register is no
// longer held by a receiver stall. Setvar emits a write request (status 0) and
// finish emits the final value with its status, then clears stack and error.
// The first error is kept; later tokens are dropped until finish.
module rpn_stack_expression_evaluator_top #(
    parameter int STACK_DEPTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration
    input  logic                i_cfg_we,
    input  logic [0:0]          i_cfg_idx,
    input  logic [0:0]          i_cfg_data,
    // token items
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [4:0]          i_operation,
    input  logic signed [63:0]  i_operand_value,
    input  logic [15:0]         i_var_id,
    input  logic                i_value_valid,
    // result items
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_result_kind,
    output logic [15:0]         o_var_id_out,
    output logic signed [63:0]  o_value_out,
    output logic [3:0]          o_status
);
    rpn_pkg::t_cmd w_cmd;
    rpn_pkg::t_sts w_sts;
    logic [$clog2(STACK_DEPTH+1)-1:0] w_sp;

    rpn_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall), .i_sts(w_sts), .o_cmd(w_cmd)
    );

    rpn_dp #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_sts(w_sts),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_operation(i_operation), .i_operand_value(i_operand_value),
        .i_var_id(i_var_id), .i_value_valid(i_value_valid),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_result_kind(o_result_kind), .o_var_id_out(o_var_id_out),
        .o_value_out(o_value_out), .o_status(o_status), .o_sp(w_sp)
    );

    // stack pointer never exceeds depth
    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sp <= ($clog2(STACK_DEPTH+1))'(STACK_DEPTH))
        else $error("stack pointer beyond depth");

    // a write request always carries status ok
    a_wr_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result_kind == rpn_pkg::KIND_WRITE) |-> o_status == rpn_pkg::ST_OK)
        else $error("write request with nonzero status");

    // finish leaves an empty stack
    a_fin_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.fin |=> w_sp == '0)
        else $error("stack not cleared at finish");
endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the postfix evaluator against a built-in predictor of the stack, the
// error latch and the two enable registers, under random sender gaps and
// receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int DEPTH     = 32;
    localparam int WDOG_MAX  = 4000;

    typedef struct packed {
        logic        kind;
        logic [15:0] vid;
        logic [63:0] val;
        logic [3:0]  st;
    } t_res;

    logic        i_clk, i_rst_n;
    logic        i_cfg_we;
    logic [0:0]  i_cfg_idx, i_cfg_data;
    logic        i_in_valid, o_in_stall;
    logic [4:0]  i_operation;
    logic signed [63:0] i_operand_value;
    logic [15:0] i_var_id;
    logic        i_value_valid;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_result_kind;
    logic [15:0] o_var_id_out;
    logic signed [63:0] o_value_out;
    logic [3:0]  o_status;

    rpn_stack_expression_evaluator_top #(.STACK_DEPTH(DEPTH)) u_top (.*);

    // predictor state
    logic [63:0] eval_stack [DEPTH];
    int          eval_sp;
    logic [3:0]  eval_err;
    logic        rd_en, wr_en;
    t_res        pending_res [$];

    int  errors = 0;
    int  idle_pct, stall_pct;
    int  wdog = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic void latch_err(logic [3:0] c);
        if (eval_err == rpn_pkg::ST_OK) eval_err = c;
    endfunction

    function automatic void push_val(logic [63:0] v);
        if (eval_sp >= DEPTH) latch_err(rpn_pkg::ST_OVERFLOW);
        else begin
            eval_stack[eval_sp] = v;
            eval_sp++;
        end
    endfunction

    function automatic logic [63:0] abs64(logic [63:0] v);
        return v[63] ? -v : v;
    endfunction

    function automatic void eval_token(rpn_pkg::t_op op, logic [63:0] opnd,
                                       logic [15:0] vid, logic vv);
        logic [63:0] a, b, c, r, q;
        logic [3:0]  st;
        t_res        res;
        if (op == rpn_pkg::OP_FINISH) begin
            st = eval_err;
            r  = '0;
            if (st == rpn_pkg::ST_OK) begin
                if (eval_sp != 1) st = rpn_pkg::ST_DEPTH;
                else r = eval_stack[0];
            end
            res = '{rpn_pkg::KIND_RESULT, 16'd0, r, st};
            pending_res.push_back(res);
            eval_sp  = 0;
            eval_err = rpn_pkg::ST_OK;
            return;
        end
        if (eval_err != rpn_pkg::ST_OK) return;
        case (op)
            rpn_pkg::OP_LIT: push_val(opnd);
            rpn_pkg::OP_GETVAR: begin
                if (!rd_en) latch_err(rpn_pkg::ST_NOREAD);
                else if (!vv) latch_err(rpn_pkg::ST_BADVALUE);
                else push_val(opnd);
            end
            rpn_pkg::OP_SETVAR: begin
                if (eval_sp == 0) latch_err(rpn_pkg::ST_UNDERFLW);
                else if (!wr_en) latch_err(rpn_pkg::ST_NOWRITE);
                else begin
                    res = '{rpn_pkg::KIND_WRITE, vid, eval_stack[eval_sp-1], rpn_pkg::ST_OK};
                    pending_res.push_back(res);
                end
            end
            rpn_pkg::OP_NEG, rpn_pkg::OP_PLUS, rpn_pkg::OP_LNOT, rpn_pkg::OP_CPL: begin
                if (eval_sp < 1) latch_err(rpn_pkg::ST_UNDERFLW);
                else begin
                    eval_sp--;
                    a = eval_stack[eval_sp];
                    case (op)
                        rpn_pkg::OP_NEG:  r = -a;
                        rpn_pkg::OP_PLUS: r = a;
                        rpn_pkg::OP_LNOT: r = (a == 0);
                        default: r = ~a;
                    endcase
                    push_val(r);
                end
            end
            rpn_pkg::OP_SEL: begin
                if (eval_sp < 3) latch_err(rpn_pkg::ST_UNDERFLW);
                else begin
                    c = eval_stack[eval_sp-1];
                    b = eval_stack[eval_sp-2];
                    a = eval_stack[eval_sp-3];
                    eval_sp -= 3;
                    push_val(a != 0 ? b : c);
                end
            end
            rpn_pkg::OP_U28, rpn_pkg::OP_U29, rpn_pkg::OP_U30, rpn_pkg::OP_U31:
                latch_err(rpn_pkg::ST_UNKNOWN);
            default: begin
                // binary: a is second from top, b is top
                if (eval_sp < 2) latch_err(rpn_pkg::ST_UNDERFLW);
                else begin
                    b = eval_stack[eval_sp-1];
                    a = eval_stack[eval_sp-2];
                    eval_sp -= 2;
                    if ((op == rpn_pkg::OP_DIV || op == rpn_pkg::OP_MOD) && b == 0) begin
                        latch_err(rpn_pkg::ST_DIVZERO);
                        return;
                    end
                    case (op)
                        rpn_pkg::OP_EQ:   r = (a == b);
                        rpn_pkg::OP_NE:   r = (a != b);
                        rpn_pkg::OP_LT:   r = ($signed(a) < $signed(b));
                        rpn_pkg::OP_GT:   r = ($signed(a) > $signed(b));
                        rpn_pkg::OP_LE:   r = ($signed(a) <= $signed(b));
                        rpn_pkg::OP_GE:   r = ($signed(a) >= $signed(b));
                        rpn_pkg::OP_LAND: r = (a != 0 && b != 0);
                        rpn_pkg::OP_LOR:  r = (a != 0 || b != 0);
                        rpn_pkg::OP_LXOR: r = ((a != 0) != (b != 0));
                        rpn_pkg::OP_BAND: r = a & b;
                        rpn_pkg::OP_BOR:  r = a | b;
                        rpn_pkg::OP_BXOR: r = a ^ b;
                        rpn_pkg::OP_MUL:  r = a * b;
                        rpn_pkg::OP_DIV: begin
                            q = abs64(a) / abs64(b);
                            r = (a[63] != b[63]) ? -q : q;
                        end
                        rpn_pkg::OP_MOD: begin
                            q = abs64(a) % abs64(b);
                            r = a[63] ? -q : q;
                        end
                        rpn_pkg::OP_ADD:  r = a + b;
                        rpn_pkg::OP_SUB:  r = a - b;
                        rpn_pkg::OP_SHL:  r = a << b[5:0];
                        default: r = $signed(a) >>> b[5:0];
                    endcase
                    push_val(r);
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------------
    // Sends one item; random gaps before it follow idle_pct. Valid stays up
    // after acceptance until the next item or a drain takes over.
    task automatic send_token(rpn_pkg::t_op op, logic [63:0] opnd = 64'd0,
                              logic [15:0] vid = 16'd0, logic vv = 1'b1);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_operation     <= op;
        i_operand_value <= opnd;
        i_var_id        <= vid;
        i_value_valid   <= vv;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        eval_token(op, opnd, vid, vv);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_res.size() != 0) @(negedge i_clk);
        // a token that produces nothing may still be in flight, such as a div
        repeat (100) @(negedge i_clk);
    endtask

    task automatic write_cfg(logic [0:0] idx, logic val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == rpn_pkg::REG_RD_EN) rd_en = val;
        else wr_en = val;
        @(negedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        case ($urandom_range(7))
            0: v = 64'h8000_0000_0000_0000;
            1: v = 64'h7fff_ffff_ffff_ffff;
            2: v = '1;
            3: v = '0;
            4: v = 64'($urandom_range(70));
            5: v = 64'd0 - 64'($urandom_range(70));
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        // overflow/underflow/zero divide/ wrap cases, disabled var access, unknown token, empty finish
        send_token(rpn_pkg::OP_LIT, 64'h8000_0000_0000_0000);
        send_token(rpn_pkg::OP_LIT, '1);
        send_token(rpn_pkg::OP_DIV);            // most negative / -1 wraps
        send_token(rpn_pkg::OP_FINISH);
        send_token(rpn_pkg::OP_LIT, 64'h8000_0000_0000_0000);
        send_token(rpn_pkg::OP_LIT, '1);
        send_token(rpn_pkg::OP_MOD);
        send_token(rpn_pkg::OP_FINISH);
        send_token(rpn_pkg::OP_LIT, 64'd5);
        send_token(rpn_pkg::OP_LIT, 64'd0);
        send_token(rpn_pkg::OP_DIV);            // divide by zero
        send_token(rpn_pkg::OP_FINISH);
        send_token(rpn_pkg::OP_ADD);            // underflow
        send_token(rpn_pkg::OP_FINISH);
        send_token(rpn_pkg::OP_GETVAR, 64'd1, 16'hffff);  // read disabled
        send_token(rpn_pkg::OP_FINISH);
        send_token(rpn_pkg::OP_LIT, 64'd1);
        send_token(rpn_pkg::OP_SETVAR, 64'd0, 16'hffff);  // write disabled
        send_token(rpn_pkg::OP_FINISH);
        send_token(rpn_pkg::OP_U31);            // unknown token
        send_token(rpn_pkg::OP_FINISH);
        send_token(rpn_pkg::OP_FINISH);         // empty -> depth
        for (int i = 0; i <= DEPTH; i++) send_token(rpn_pkg::OP_LIT, 64'(i));  // overflow
        send_token(rpn_pkg::OP_FINISH);
        drain_results();
    endtask

    task automatic test_vars();
        write_cfg(rpn_pkg::REG_RD_EN, 1'b1);
        write_cfg(rpn_pkg::REG_WR_EN, 1'b1);
        send_token(rpn_pkg::OP_GETVAR, 64'h7fff_ffff_ffff_ffff, 16'h0000, 1'b1);
        send_token(rpn_pkg::OP_SETVAR, 64'd0, 16'hffff);
        send_token(rpn_pkg::OP_SETVAR, 64'd0, 16'h5a5a);
        send_token(rpn_pkg::OP_FINISH);
        send_token(rpn_pkg::OP_GETVAR, 64'd3, 16'd7, 1'b0);  // bad value
        send_token(rpn_pkg::OP_FINISH);
        send_token(rpn_pkg::OP_SETVAR, 64'd0, 16'd1);        // empty stack
        send_token(rpn_pkg::OP_FINISH);
        drain_results();
    endtask

    // Well-formed expressions with random content, sprinkled with noise.
    task automatic test_random(int n_items);
        int            sent, d;
        rpn_pkg::t_op  op;
        sent = 0;
        d = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 8) op = rpn_pkg::t_op'($urandom_range(31));
            else if (d < 1 || (d < 12 && $urandom_range(2) == 0))
                op = $urandom_range(3) == 0 ? rpn_pkg::OP_GETVAR : rpn_pkg::OP_LIT;
            else if (d >= 3 && $urandom_range(9) == 0) op = rpn_pkg::OP_SEL;
            else if ($urandom_range(6) == 0) op = rpn_pkg::t_op'($urandom_range(23, 26));
            else if ($urandom_range(8) == 0) op = rpn_pkg::OP_SETVAR;
            else if (d == 1 && $urandom_range(3) == 0) op = rpn_pkg::OP_FINISH;
            else op = rpn_pkg::t_op'($urandom_range(4, 22));
            send_token(op, rand64(), 16'($urandom), $urandom_range(15) != 0);
            sent++;
            d = eval_sp;
            if (eval_err != rpn_pkg::ST_OK && $urandom_range(3) == 0) begin
                send_token(rpn_pkg::OP_FINISH);
                sent++;
                d = 0;
            end
        end
        send_token(rpn_pkg::OP_FINISH);
        drain_results();
    endtask

    // ------------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_res.size() == 0) begin
                $error("unexpected result item, status %0d", o_status);
                errors++;
            end else begin
                e = pending_res.pop_front();
                if (o_result_kind !== e.kind) begin
                    $error("result_kind exp %0d got %0d", e.kind, o_result_kind);
                    errors++;
                end
                if (o_var_id_out !== e.vid) begin
                    $error("var_id_out exp %0h got %0h", e.vid, o_var_id_out);
                    errors++;
                end
                if (o_value_out !== e.val) begin
                    $error("value_out exp %0h got %0h", e.val, o_value_out);
                    errors++;
                end
                if (o_status !== e.st) begin
                    $error("status exp %0d got %0d", e.st, o_status);
                    errors++;
                end
            end
        end
    end

    // receiver stall, redrawn every falling edge
    always @(negedge i_clk)
        i_out_stall <= ($urandom_range(99) < stall_pct);

    // watchdog on accepted traffic
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) wdog <= 0;
        else wdog <= wdog + 1;
        if (wdog >= WDOG_MAX) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        idle_pct = 0; stall_pct = 0;
        eval_sp = 0; eval_err = rpn_pkg::ST_OK; rd_en = 0; wr_en = 0;
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        i_in_valid = 1'b0; i_operation = '0; i_operand_value = '0;
        i_var_id = '0; i_value_valid = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_vars();
        test_random(330);
        idle_pct = 79;
        write_cfg(rpn_pkg::REG_RD_EN, 1'b0);
        test_random(330);
        idle_pct = 0; stall_pct = 79;
        write_cfg(rpn_pkg::REG_WR_EN, 1'b0);
        write_cfg(rpn_pkg::REG_RD_EN, 1'b1);
        test_random(330);
        idle_pct = 8; stall_pct = 8;
        write_cfg(rpn_pkg::REG_WR_EN, 1'b1);
        test_random(330);

        if (errors == 0 && pending_res.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
